// ----- sv/tgrc_pkg.sv -----
`timescale 1ns / 1ps

package tgrc_pkg;

    // Fixed field widths of the channel payloads.
    localparam int CELL_ROW_W = 4;
    localparam int CELL_COL_W = 5;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    // Signed width that holds a rectangle's far edge, x + w - 1.
    localparam int SPAN_W     = 18;

    // Item actions.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Request payload: one cell write or one rectangle query.
    typedef struct packed {
        logic                       action;
        logic [CELL_ROW_W-1:0]      cell_row;
        logic [CELL_COL_W-1:0]      cell_col;
        logic                       solid;
        logic signed [COORD_W-1:0]  rect_x;
        logic signed [COORD_W-1:0]  rect_y;
        logic [SIZE_W-1:0]          rect_w;
        logic [SIZE_W-1:0]          rect_h;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic hit;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic row_rd;
        logic row_wr;
        logic scan_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_valid;
        logic req_query;
        logic wr_in_grid;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// ----- sv/tgrc_chan_if.sv -----
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transaction.
interface tgrc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/tgrc_ctrl.sv -----
`timescale 1ns / 1ps

module tgrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  tgrc_pkg::status_t status,
    output tgrc_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WR_RD = 3'd1;
    localparam logic [2:0] S_WR_WR = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.req_query ? S_SCAN : S_WR_RD;
                end
            end
            S_WR_RD:
            begin
                // Writes outside the grid are dropped.
                if (status.wr_in_grid)
                begin
                    cmd.row_rd = 1'b1;
                    state_next = S_WR_WR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WR_WR:
            begin
                cmd.row_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.row_rd    = 1'b1;
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A row write always follows the read of that row.
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_wr |-> $past(cmd.row_rd))
        else $error("row write without preceding row read");

    // A result is never loaded in the cycle right after an item is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.load_out)
        else $error("result loaded too early");

endmodule

// ----- sv/tgrc_dp.sv -----
`timescale 1ns / 1ps

module tgrc_dp #(
    parameter int GRID_ROWS  = 16,
    parameter int GRID_COLS  = 32,
    parameter int TILE_PIX_W = 32,
    parameter int TILE_PIX_H = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    tgrc_chan_if.sink         req,
    tgrc_chan_if.source       rsp,
    input  tgrc_pkg::cmd_t    cmd,
    output tgrc_pkg::status_t status
);

    localparam int ROW_AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_AW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int SW     = tgrc_pkg::SPAN_W;
    localparam logic signed [SW-1:0] COL_NEG_LIM = SW'(0) - SW'(TILE_PIX_W);
    localparam logic signed [SW-1:0] ROW_NEG_LIM = SW'(0) - SW'(TILE_PIX_H);
    localparam logic [ROW_AW-1:0]    LAST_ROW    = ROW_AW'(GRID_ROWS - 1);

    tgrc_pkg::req_t         item_reg;
    logic [GRID_COLS-1:0]   col_mask_reg;
    logic [GRID_COLS-1:0]   col_mask_next;
    logic [GRID_ROWS-1:0]   row_mask_reg;
    logic [GRID_ROWS-1:0]   row_mask_next;
    logic [ROW_AW-1:0]      scan_row_reg;
    logic [ROW_AW-1:0]      scan_row_next;
    logic                   pend_reg;
    logic [ROW_AW-1:0]      pend_row_reg;
    logic [GRID_COLS-1:0]   rd_data_reg;
    logic                   rd_valid_reg;
    logic                   hit_acc_reg;
    logic                   hit_acc_next;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [GRID_ROWS-1:0]   row_valid_reg;
    logic [GRID_COLS-1:0]   mem [GRID_ROWS];

    logic [ROW_AW-1:0]      rd_addr;
    logic [COL_AW-1:0]      col_idx;
    logic [GRID_COLS-1:0]   eff_row;
    logic [GRID_COLS-1:0]   new_row;
    logic signed [SW-1:0]   x_ext;
    logic signed [SW-1:0]   y_ext;
    logic signed [SW-1:0]   x_end;
    logic signed [SW-1:0]   y_end;
    logic signed [SW-1:0]   x_end_c;
    logic signed [SW-1:0]   y_end_c;

    // Channel handshakes and status.
    assign req.ready          = cmd.in_ready;
    assign rsp.valid          = out_valid_reg;
    assign rsp.payload.hit    = out_hit_reg;
    assign status.req_valid   = req.valid;
    assign status.req_query   = (req.payload.action == tgrc_pkg::ACT_QUERY);
    assign status.wr_in_grid  = ({28'b0, item_reg.cell_row} < 32'(GRID_ROWS))
                              && ({27'b0, item_reg.cell_col} < 32'(GRID_COLS));
    assign status.scan_last   = (scan_row_reg == LAST_ROW);
    assign status.out_free    = !out_valid_reg || rsp.ready;

    // Column and row span masks of the incoming rectangle. A tile index c
    // lies in the span when (c+1)*tile > left edge and c*tile <= right edge;
    // a right edge less than one tile left of the grid still maps to 0.
    always_comb
    begin
        x_ext   = SW'(req.payload.rect_x);
        y_ext   = SW'(req.payload.rect_y);
        x_end   = x_ext + $signed({3'b0, req.payload.rect_w}) - SW'(1);
        y_end   = y_ext + $signed({3'b0, req.payload.rect_h}) - SW'(1);
        x_end_c = (x_end < 0 && x_end > COL_NEG_LIM) ? SW'(0) : x_end;
        y_end_c = (y_end < 0 && y_end > ROW_NEG_LIM) ? SW'(0) : y_end;
        for (int c = 0; c < GRID_COLS; c++)
        begin
            col_mask_next[c] = ($signed(SW'((c + 1) * TILE_PIX_W)) > x_ext)
                             && ($signed(SW'(c * TILE_PIX_W)) <= x_end_c)
                             && (req.payload.rect_w != '0);
        end
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            row_mask_next[r] = ($signed(SW'((r + 1) * TILE_PIX_H)) > y_ext)
                             && ($signed(SW'(r * TILE_PIX_H)) <= y_end_c)
                             && (req.payload.rect_h != '0);
        end
    end

    // Item and span capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg     <= req.payload;
            col_mask_reg <= col_mask_next;
            row_mask_reg <= row_mask_next;
        end
    end

    // Row read address: the written cell's row, or the scan row.
    assign rd_addr = (item_reg.action == tgrc_pkg::ACT_QUERY) ? scan_row_reg
                                                              : ROW_AW'(item_reg.cell_row);
    assign col_idx = COL_AW'(item_reg.cell_col);

    // A row never written since reset reads as empty.
    assign eff_row = rd_valid_reg ? rd_data_reg : '0;

    // Read-modify-write of the addressed cell.
    always_comb
    begin
        new_row          = eff_row;
        new_row[col_idx] = item_reg.solid;
    end

    // Occupancy memory, one word per grid row.
    always_ff @(posedge clk)
    begin
        if (cmd.row_wr)
        begin
            mem[rd_addr] <= new_row;
        end
        if (cmd.row_rd)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // Per-row valid bits, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.row_wr)
        begin
            row_valid_reg[rd_addr] <= 1'b1;
        end
    end

    // Scan counter and hit accumulation.
    always_comb
    begin
        scan_row_next = scan_row_reg;
        if (cmd.capture)
        begin
            scan_row_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_row_next = scan_row_reg + 1'b1;
        end

        hit_acc_next = hit_acc_reg;
        if (cmd.capture)
        begin
            hit_acc_next = 1'b0;
        end
        else if (pend_reg)
        begin
            hit_acc_next = hit_acc_reg
                         | ((|(eff_row & col_mask_reg)) & row_mask_reg[pend_row_reg]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg <= '0;
            pend_reg     <= 1'b0;
            pend_row_reg <= '0;
            hit_acc_reg  <= 1'b0;
        end
        else
        begin
            scan_row_reg <= scan_row_next;
            pend_reg     <= cmd.row_rd && (item_reg.action == tgrc_pkg::ACT_QUERY);
            pend_row_reg <= rd_addr;
            hit_acc_reg  <= hit_acc_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hit_reg <= hit_acc_reg;
        end
    end

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten");

    // Only cells inside the grid are written.
    a_wr_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_wr |-> status.wr_in_grid)
        else $error("write outside the grid");

    // No scan read is in flight when a new item is taken.
    a_no_pend_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !pend_reg)
        else $error("scan read pending at capture");

endmodule

// ----- sv/tile_grid_rect_collision_unit.sv -----
`timescale 1ns / 1ps

// Tile grid rectangle collision unit.
// The req channel takes one transaction per item: action 0 writes one grid cell
// (cell_row, cell_col, solid), action 1 queries a pixel rectangle (rect_x,
// rect_y, rect_w, rect_h). Each query returns one transaction on rsp carrying
// hit; a write returns nothing, and a write outside the grid is dropped.
// A write steps through capture, row read and row write; a dropped write returns
// to idle without the row read. A query steps through capture with span masks,
// a read of each grid row in turn through the single read port of the occupancy
// memory, a drain step and the result load. One item is in work at a time, and
// req.ready is high only while the unit is idle.
// The result sits in an output register, so a new item is taken while it
// waits. If rsp stalls, a query that finishes holds in its final state
// until the register frees up.
// Reset clears all grid cells at once through per-row valid bits; the first
// item can be taken in the cycle after reset is released.
module tile_grid_rect_collision_unit #(
    parameter int GRID_ROWS  = 16,
    parameter int GRID_COLS  = 32,
    parameter int TILE_PIX_W = 32,
    parameter int TILE_PIX_H = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    tgrc_chan_if.sink   req,
    tgrc_chan_if.source rsp
);

    tgrc_pkg::cmd_t    cmd;
    tgrc_pkg::status_t status;

    // Sequencer.
    tgrc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Grid storage, span masks and result register.
    tgrc_dp #(
        .GRID_ROWS  (GRID_ROWS),
        .GRID_COLS  (GRID_COLS),
        .TILE_PIX_W (TILE_PIX_W),
        .TILE_PIX_H (TILE_PIX_H)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule
